### rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants of the sliding window average
// Window geometry, field widths and the beats between ring, divider and output stage.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int MAX_WINDOW = 128;
  localparam int ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

  localparam int CFG_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int FRAC_W     = 8;
  localparam int AVG_W      = 24;
  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int CNT_W      = $clog2(DVD_W);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(120);

  // saturation bounds of the average, as quotient magnitudes
  localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(64'd1 << (AVG_W - 1));
  localparam logic [AVG_W-1:0] AVG_MAX   = AVG_W'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [AVG_W-1:0] AVG_MIN   = AVG_W'(64'd1 << (AVG_W - 1));

  // ring -> divider: updated running sum
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
  } swa_sum_t;

  // divider -> output stage: finished average
  typedef struct packed {
    logic                    valid;
    logic signed [AVG_W-1:0] avg;
  } swa_avg_t;

  // zero acts as one, anything above the ring depth acts as the depth
  function automatic logic [LEN_W-1:0] eff_len(logic [CFG_W-1:0] cfg);
    int unsigned l;
    l = 32'(cfg);
    if (l == 0) l = 1;
    if (l > MAX_WINDOW) l = MAX_WINDOW;
    return LEN_W'(l);
  endfunction

endpackage

### rtl/swa_ring.sv
// ----------------------------------------------------------------------------
// swa_ring: sample ring and running sum
// Read-modify-write of one ring slot per sample, with per-slot valid bits
// so that never-written slots read as zero after reset.
// ----------------------------------------------------------------------------
module swa_ring (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [swa_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic        [swa_pkg::LEN_W-1:0]      len_i,
  output logic                                  busy_o,
  output swa_pkg::swa_sum_t                     sum_o
);

  logic signed [swa_pkg::SAMPLE_W-1:0] mem [swa_pkg::MAX_WINDOW];
  logic        [swa_pkg::MAX_WINDOW-1:0] vld_q;

  logic signed [swa_pkg::SAMPLE_W-1:0] rd_q;
  logic                                rd_vld_q;
  logic signed [swa_pkg::SAMPLE_W-1:0] smp_q;
  logic        [swa_pkg::ADDR_W-1:0]   pos_q, pos_d;
  logic signed [swa_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic                                upd_q;   // read data arrives, update this cycle
  logic                                done_q;
  logic signed [swa_pkg::SAMPLE_W-1:0] old;
  logic        [swa_pkg::LEN_W-1:0]    pos_inc;

  // read issued on the accepted beat, written back in the cycle after it; the next
  // beat is held off until the item has left the divider, so no overlap
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rd_q  <= mem[pos_q];
      smp_q <= sample_i;
    end
    if (upd_q) begin
      mem[pos_q] <= smp_q;
    end
  end

  always_comb begin
    old     = rd_vld_q ? rd_q : '0;
    sum_d   = sum_q - swa_pkg::SUM_W'(old) + swa_pkg::SUM_W'(smp_q);
    pos_inc = swa_pkg::LEN_W'(pos_q) + swa_pkg::LEN_W'(1);
    pos_d   = (pos_inc >= len_i) ? '0 : pos_q + swa_pkg::ADDR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      pos_q    <= '0;
      sum_q    <= '0;
      upd_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      upd_q  <= start_i;
      done_q <= upd_q;
      if (start_i) begin
        rd_vld_q <= vld_q[pos_q];
      end
      if (upd_q) begin
        vld_q[pos_q] <= 1'b1;
        sum_q        <= sum_d;
        pos_q        <= pos_d;
      end
    end
  end

  assign busy_o      = upd_q | done_q;
  assign sum_o.valid = done_q;
  assign sum_o.sum   = sum_q;

endmodule

### rtl/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div: iterative signed divide with saturation
// Computes sum * 256 / len truncated toward zero, one quotient bit a cycle
// on magnitudes, then restores the sign and clamps to the output range.
// ----------------------------------------------------------------------------
module swa_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swa_pkg::swa_sum_t                   req_i,
  input  logic [swa_pkg::LEN_W-1:0]           len_i,
  input  logic                                take_i,
  output logic                                busy_o,
  output swa_pkg::swa_avg_t                   res_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } div_state_e;

  div_state_e                        state_q, state_d;
  logic [swa_pkg::DVD_W-1:0]         dvd_q, dvd_d;   // dividend in, quotient out
  logic [swa_pkg::LEN_W-1:0]         rem_q, rem_d;
  logic [swa_pkg::LEN_W-1:0]         dsr_q;
  logic [swa_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic                              neg_q;
  logic [swa_pkg::LEN_W:0]           rem_sh;
  logic [swa_pkg::LEN_W:0]           rem_sub;
  logic                              ge;
  logic [swa_pkg::SUM_W-1:0]         mag;
  logic [swa_pkg::AVG_W-1:0]         avg;

  always_comb begin
    mag     = req_i.sum[swa_pkg::SUM_W-1] ? (~req_i.sum + swa_pkg::SUM_W'(1)) : req_i.sum;
    rem_sh  = {rem_q, dvd_q[swa_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[swa_pkg::LEN_W-1:0] : rem_sh[swa_pkg::LEN_W-1:0];
    dvd_d   = {dvd_q[swa_pkg::DVD_W-2:0], ge};
    cnt_d   = cnt_q - swa_pkg::CNT_W'(1);

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_i.valid) state_d = ST_RUN;
      ST_RUN:  if (cnt_q == '0) state_d = ST_HOLD;
      ST_HOLD: if (take_i)      state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      avg = (dvd_q > swa_pkg::NEG_LIMIT) ? swa_pkg::AVG_MIN
          : (~dvd_q[swa_pkg::AVG_W-1:0] + swa_pkg::AVG_W'(1));
    end else begin
      avg = (dvd_q > swa_pkg::POS_LIMIT) ? swa_pkg::AVG_MAX : dvd_q[swa_pkg::AVG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      dvd_q <= {mag, swa_pkg::FRAC_W'(0)};
      rem_q <= '0;
      dsr_q <= len_i;
      neg_q <= req_i.sum[swa_pkg::SUM_W-1];
      cnt_q <= swa_pkg::CNT_W'(swa_pkg::DVD_W - 1);
    end else if (state_q == ST_RUN) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign res_o.valid = (state_q == ST_HOLD);
  assign res_o.avg   = avg;

endmodule

### rtl/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average: boxcar moving average over a sample ring
// Signed 16-bit samples in, signed 24-bit averages with 8 fraction bits out.
// ----------------------------------------------------------------------------
// One sample is in flight at a time and each passes, from accepted beat to
// the next accepted beat, through the ring memory read, the sum update and
// write-back, the hand-over of the sum, the one-bit-a-cycle divider that
// forms sum * 256 / window_length, and the move of the average into the
// output register. The output register lets a new sample in while the
// previous average waits to be taken; a second average finished behind a
// stalled output holds the input off until it moves. The ring reads as all
// zero after reset with no clearing pass, so the average ramps up over the
// first window. window_length 0 acts as 1 and values above 128 act as 128;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_average (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swa_pkg::AVG_W-1:0]    average_o
);

  logic [swa_pkg::CFG_W-1:0]        window_length_q;
  logic [swa_pkg::LEN_W-1:0]        len;
  logic                             ring_busy, div_busy;
  logic                             start;
  logic                             load;
  swa_pkg::swa_sum_t                sum;
  swa_pkg::swa_avg_t                res;
  logic                             out_valid_q, out_valid_d;
  logic signed [swa_pkg::AVG_W-1:0] average_q;

  assign len        = swa_pkg::eff_len(window_length_q);
  assign in_stall_o = ring_busy | div_busy;
  assign start      = in_valid_i & ~in_stall_o;
  assign load       = res.valid & (~out_valid_q | ~out_stall_i);

  swa_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (sample_i),
    .len_i    (len),
    .busy_o   (ring_busy),
    .sum_o    (sum)
  );

  swa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sum),
    .len_i  (len),
    .take_i (load),
    .busy_o (div_busy),
    .res_o  (res)
  );

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      average_q <= res.avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= swa_pkg::WINDOW_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_length_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

endmodule

### verif/sliding_window_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_average_tb: self-checking bench for the boxcar averager
// Streams signed samples through the block under several window lengths,
// predicts every average from a local copy of the ring, sum and position,
// and checks each output beat in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sliding_window_average_tb;

  localparam int     ITEM_TARGET = 1650;
  localparam int     LONG_HOLD   = 400;
  localparam int     SETTLE_WAIT = 40;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint AVG_HI      = (longint'(1) <<< (swa_pkg::AVG_W - 1)) - 1;
  localparam longint AVG_LO      = -(longint'(1) <<< (swa_pkg::AVG_W - 1));

  typedef enum int {MIX_FULL, MIX_HIGH, MIX_LOW, MIX_SMALL} sample_mix_e;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                cfg_we_i    = 1'b0;
  logic [swa_pkg::CFG_W-1:0]           cfg_wdata_i = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic signed [swa_pkg::SAMPLE_W-1:0] sample_i    = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [swa_pkg::AVG_W-1:0]    average_o;

  // local copy of the averaging state
  logic signed [swa_pkg::SAMPLE_W-1:0] ring_copy [swa_pkg::MAX_WINDOW];
  logic signed [swa_pkg::SUM_W-1:0]    ring_sum;
  int                                  ring_pos;
  logic [swa_pkg::CFG_W-1:0]           window_cfg;

  logic signed [swa_pkg::SAMPLE_W-1:0] pending_samples [$];
  logic signed [swa_pkg::AVG_W-1:0]    expected_averages [$];

  int     queued_count   = 0;
  int     mismatch_count = 0;
  int     send_gap       = 0;
  int     take_gap       = 0;
  int     hold_token     = 0;
  int     hold_seen      = 0;
  bit     calm_stretch   = 1'b0;
  longint cycle_count    = 0;

  sliding_window_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_wait();
    return calm_stretch ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic signed [swa_pkg::SAMPLE_W-1:0] draw_sample(sample_mix_e mix);
    int unsigned pick;
    pick = $urandom_range(0, 7);
    case (mix)
      MIX_HIGH:  return (pick == 0) ? swa_pkg::SAMPLE_W'($urandom)
                       : 16'sd32767 - swa_pkg::SAMPLE_W'($urandom_range(0, 255));
      MIX_LOW:   return (pick == 0) ? swa_pkg::SAMPLE_W'($urandom)
                       : -16'sd32768 + swa_pkg::SAMPLE_W'($urandom_range(0, 255));
      MIX_SMALL: return swa_pkg::SAMPLE_W'($urandom_range(0, 16)) - swa_pkg::SAMPLE_W'(8);
      default: begin
        if (pick == 0) return 16'sd32767;
        if (pick == 1) return -16'sd32768;
        return swa_pkg::SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  // ring update and scaled division for one accepted sample
  function automatic void predict_average(logic signed [swa_pkg::SAMPLE_W-1:0] s);
    int unsigned len;
    longint      scaled;
    len = 32'(window_cfg);
    if (len == 0) len = 1;
    if (len > swa_pkg::MAX_WINDOW) len = swa_pkg::MAX_WINDOW;
    ring_sum = ring_sum - ring_copy[ring_pos] + s;
    ring_copy[ring_pos] = s;
    // a position left beyond a shrunk window still takes this sample, then wraps
    ring_pos = (ring_pos + 1 >= len) ? 0 : ring_pos + 1;
    scaled = (longint'(ring_sum) * 256) / longint'(len);
    if (scaled > AVG_HI) scaled = AVG_HI;
    if (scaled < AVG_LO) scaled = AVG_LO;
    expected_averages.push_back(scaled[swa_pkg::AVG_W-1:0]);
  endfunction

  // driver: one sample per beat, random gap after each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      send_gap   = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        predict_average(sample_i);
        send_gap = draw_wait();
      end
      if (send_gap == 0 && pending_samples.size() != 0) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // monitor: checks each taken beat, then stalls for a random count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      take_gap    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected average, expected none, got %0d", $time, average_o);
          mismatch_count++;
        end else if (average_o !== expected_averages[0]) begin
          $display("%0t: average mismatch, expected %0d, got %0d",
                   $time, expected_averages[0], average_o);
          mismatch_count++;
          void'(expected_averages.pop_front());
        end else begin
          void'(expected_averages.pop_front());
        end
        take_gap = draw_wait();
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        take_gap  = LONG_HOLD;
      end
      if (take_gap > 0) begin
        out_stall_i <= 1'b1;
        take_gap--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_sample(logic signed [swa_pkg::SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    queued_count++;
  endtask

  // wait for every beat to drain, then for the divider to go quiet
  task automatic settle_block();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_averages.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic set_window(logic [swa_pkg::CFG_W-1:0] value);
    settle_block();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_cfg  = value;
  endtask

  initial begin
    logic [swa_pkg::CFG_W-1:0] window;
    int                        phase;
    int                        count;
    sample_mix_e               mix;

    for (int i = 0; i < swa_pkg::MAX_WINDOW; i++) ring_copy[i] = '0;
    ring_sum   = '0;
    ring_pos   = 0;
    window_cfg = swa_pkg::WINDOW_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // field extremes at the reset window
    push_sample(16'sd32767);
    push_sample(-16'sd32768);
    push_sample(16'sd0);
    push_sample(-16'sd1);
    push_sample(16'sd1);

    // shrink with stale samples held in the sum: both saturation limits
    set_window(8'd3);
    repeat (3) push_sample(16'sd32767);
    set_window(8'd2);
    push_sample(16'sd32767);
    push_sample(-16'sd32768);
    set_window(8'd3);
    repeat (3) push_sample(-16'sd32768);
    set_window(8'd2);
    push_sample(-16'sd32768);

    // zero acts as one, oversize acts as the ring depth
    set_window(8'd0);
    push_sample(16'sd100);
    push_sample(-16'sd100);
    set_window(8'd255);
    push_sample(16'sd12345);
    push_sample(-16'sd4321);
    set_window(8'd128);
    push_sample(16'sd7);

    // position left past a shrunk window
    set_window(8'd1);
    push_sample(16'sd55);
    set_window(8'd8);
    repeat (5) push_sample(swa_pkg::SAMPLE_W'($urandom));
    set_window(8'd3);
    push_sample(16'sd999);

    phase = 0;
    while (queued_count < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 6))
          0:       window = 8'd0;
          1:       window = 8'd1;
          2:       window = 8'd2;
          3:       window = 8'd127;
          4:       window = 8'd128;
          5:       window = 8'd129;
          default: window = 8'd255;
        endcase
      end else begin
        window = swa_pkg::CFG_W'($urandom_range(0, 255));
      end
      // every phase boundary also pauses the sender until all averages are in
      set_window(window);
      calm_stretch = ($urandom_range(0, 4) == 0);
      if (phase == 3) hold_token++;
      count = $urandom_range(20, 100);
      mix   = sample_mix_e'($urandom_range(0, 3));
      repeat (count) push_sample(draw_sample(mix));
      phase++;
    end

    settle_block();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
